FILE: rtl/kabf_pkg.sv
// Package for the angle and gyro bias Kalman filter unit.
// Holds payload types, register indexes and the datapath command encoding.
`default_nettype none
package kabf_pkg;

   typedef struct packed {
      logic signed [31:0] measured_angle;
      logic signed [31:0] gyro_rate;
   } req_payload_type;

   typedef struct packed {
      logic signed [31:0] filtered_angle;
      logic signed [31:0] bias_estimate;
   } rsp_payload_type;

   localparam logic [1:0] CSR_ANGLE_NOISE   = 2'd0;
   localparam logic [1:0] CSR_BIAS_NOISE    = 2'd1;
   localparam logic [1:0] CSR_MEASURE_NOISE = 2'd2;
   localparam logic [1:0] CSR_SAMPLE_PERIOD = 2'd3;

   // Datapath micro-operations, one per controller step.
   typedef enum logic [4:0] {
      OP_NOP,
      OP_LOAD,        // latch input item
      OP_RATE,        // r0 = sat(gyro - bias)
      OP_MUL_DT_R0,   // r0 = dt * r0
      OP_ANGLE_ADD,   // angle = sat(angle + r0)
      OP_MUL_DT_BB,   // r1 = dt * cov_bb
      OP_T_SUB_AB,    // r0 = sat(r1 - cov_ab)
      OP_T_SUB_BA,    // r0 = sat(r0 - cov_ba)
      OP_T_ADD_QA,    // r0 = sat(r0 + angle_noise)
      OP_AA_ADD,      // cov_aa = sat(cov_aa + dt * r0)
      OP_AB_BA_SUB,   // cov_ab -= r1, cov_ba -= r1
      OP_MUL_QB_DT,   // r0 = bias_noise * dt
      OP_BB_ADD,      // cov_bb = sat(cov_bb + r0)
      OP_S_FORM,      // s = sat(cov_aa + measure_noise)
      OP_DIV_K0,      // start k0 = cov_aa / s
      OP_DIV_K1,      // latch k0, start k1 = cov_ba / s
      OP_K1_DONE,     // latch k1
      OP_Y_FORM,      // y = sat(meas - angle)
      OP_MUL_K0_Y,    // r0 = k0 * y
      OP_MUL_K1_Y,    // angle += r0, r0 = k1 * y
      OP_BIAS_ADD,    // bias += r0
      OP_MUL_K0_AA,   // r0 = k0 * aa
      OP_MUL_K0_AB,   // r1 = k0 * ab
      OP_MUL_K1_AA,   // r2 = k1 * aa
      OP_MUL_K1_AB,   // r3 = k1 * ab
      OP_COV_UPD      // apply all four covariance updates
   } op_type;

   typedef struct packed {
      op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic div_busy;
   } dp_status_type;

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sh0_7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // Q16.16 product with round-half-up, saturated; shift is a floor so ties go up.
   function automatic logic signed [31:0] qround(input logic signed [63:0] p);
      logic signed [63:0] r;
      r = (p + 64'sd32768) >>> 16;
      if (r > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (r < -64'sh8000_0000) return 32'sh8000_0000;
      return r[31:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/kabf_divider.sv
// Restoring divider for Q16.16 gains: (num << 16) / den, truncated, saturated.
// Uses kabf_pkg; one quotient bit per cycle.
`default_nettype none
module kabf_divider
   import kabf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic signed [31:0] den,
   output logic                    busy,
   output logic signed [31:0]      quot
);

   logic [47:0] dividend_ff, dividend_in;
   logic [47:0] rem_ff, rem_in;
   logic [31:0] divisor_ff, divisor_in;
   logic [5:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic        zero_ff, zero_in;
   logic [48:0] trial;
   logic [47:0] num_mag;
   logic signed [49:0] sq;

   assign num_mag = num[31] ? {16'd0, -num} : {16'd0, num};
   assign trial   = {rem_ff, dividend_ff[47]} - {17'd0, divisor_ff};

   always_comb begin
      dividend_in = dividend_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      count_in    = count_ff;
      busy_in     = busy_ff;
      neg_in      = neg_ff;
      zero_in     = zero_ff;
      if (start) begin
         dividend_in = num_mag << 16;
         rem_in      = '0;
         divisor_in  = den[31] ? -den : den;
         count_in    = 6'd48;
         busy_in     = 1'b1;
         neg_in      = num[31] ^ den[31];
         zero_in     = (den == 32'sd0);
      end else if (busy_ff) begin
         if (!trial[48]) begin
            rem_in      = trial[47:0];
            dividend_in = {dividend_ff[46:0], 1'b1};
         end else begin
            rem_in      = {rem_ff[46:0], dividend_ff[47]};
            dividend_in = {dividend_ff[46:0], 1'b0};
         end
         count_in = count_ff - 6'd1;
         if (count_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      dividend_ff <= dividend_in;
      rem_ff      <= rem_in;
      divisor_ff  <= divisor_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
   end

   // quotient magnitude below 2^48; apply sign and saturate
   assign sq = neg_ff ? -$signed({2'b00, dividend_ff}) : $signed({2'b00, dividend_ff});

   always_comb begin
      if (zero_ff) quot = '0;
      else if (sq > 50'sh7FFF_FFFF) quot = 32'sh7FFF_FFFF;
      else if (sq < -50'sh8000_0000) quot = 32'sh8000_0000;
      else quot = sq[31:0];
   end

   assign busy = busy_ff;

endmodule
`default_nettype wire

FILE: rtl/kabf_datapath.sv
// Datapath of the Kalman filter unit: state, config registers, one multiplier, divider.
// Uses kabf_pkg and kabf_divider; driven by kabf_control one op per cycle, except while it waits on the divider.
`default_nettype none
module kabf_datapath
   import kabf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire dp_cmd_type      cmd,
   output dp_status_type        status,
   input  wire req_payload_type req_payload,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_we,
   input  wire logic [1:0]      csr_index,
   input  wire logic [31:0]     csr_wdata
);

   logic [30:0] angle_noise_ff, bias_noise_ff, measure_noise_ff;
   logic [16:0] sample_period_ff;
   logic signed [31:0] angle_ff, bias_ff, aa_ff, ab_ff, ba_ff, bb_ff;
   logic signed [31:0] meas_ff, gyro_ff;
   logic signed [31:0] r0_ff, r1_ff, r2_ff, r3_ff, s_ff, k0_ff, k1_ff, y_ff;
   logic signed [31:0] ma, mb, prod_q;
   logic signed [63:0] prod;
   logic               div_start;
   logic signed [31:0] div_num, div_quot;
   logic               div_busy;
   logic signed [31:0] dt;

   assign dt = $signed({15'd0, sample_period_ff});

   // single shared multiplier, operands picked by the op
   always_comb begin
      ma = dt;
      mb = r0_ff;
      case (cmd.op)
         OP_MUL_DT_R0: begin ma = dt; mb = r0_ff; end
         OP_MUL_DT_BB: begin ma = dt; mb = bb_ff; end
         OP_AA_ADD:    begin ma = dt; mb = r0_ff; end
         OP_MUL_QB_DT: begin ma = $signed({1'b0, bias_noise_ff}); mb = dt; end
         OP_MUL_K0_Y:  begin ma = k0_ff; mb = y_ff; end
         OP_MUL_K1_Y:  begin ma = k1_ff; mb = y_ff; end
         OP_MUL_K0_AA: begin ma = k0_ff; mb = aa_ff; end
         OP_MUL_K0_AB: begin ma = k0_ff; mb = ab_ff; end
         OP_MUL_K1_AA: begin ma = k1_ff; mb = aa_ff; end
         OP_MUL_K1_AB: begin ma = k1_ff; mb = ab_ff; end
         default:      begin ma = dt; mb = r0_ff; end
      endcase
   end

   assign prod   = ma * mb;
   assign prod_q = qround(prod);

   assign div_start = (cmd.op == OP_DIV_K0) || (cmd.op == OP_DIV_K1);
   assign div_num   = (cmd.op == OP_DIV_K1) ? ba_ff : aa_ff;

   kabf_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (s_ff),
      .busy  (div_busy),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_noise_ff   <= 31'd66;
         bias_noise_ff    <= 31'd197;
         measure_noise_ff <= 31'd32768;
         sample_period_ff <= 17'd328;
         angle_ff <= '0;
         bias_ff  <= '0;
         aa_ff    <= '0;
         ab_ff    <= '0;
         ba_ff    <= '0;
         bb_ff    <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_ANGLE_NOISE:   angle_noise_ff   <= csr_wdata[30:0];
               CSR_BIAS_NOISE:    bias_noise_ff    <= csr_wdata[30:0];
               CSR_MEASURE_NOISE: measure_noise_ff <= csr_wdata[30:0];
               CSR_SAMPLE_PERIOD: sample_period_ff <= csr_wdata[16:0];
               default: ;
            endcase
         end
         case (cmd.op)
            OP_LOAD: begin
               meas_ff <= req_payload.measured_angle;
               gyro_ff <= req_payload.gyro_rate;
            end
            OP_RATE:      r0_ff <= sat32(34'(gyro_ff) - 34'(bias_ff));
            OP_MUL_DT_R0: r0_ff <= prod_q;
            OP_ANGLE_ADD: angle_ff <= sat32(34'(angle_ff) + 34'(r0_ff));
            OP_MUL_DT_BB: r1_ff <= prod_q;
            OP_T_SUB_AB:  r0_ff <= sat32(34'(r1_ff) - 34'(ab_ff));
            OP_T_SUB_BA:  r0_ff <= sat32(34'(r0_ff) - 34'(ba_ff));
            OP_T_ADD_QA:  r0_ff <= sat32(34'(r0_ff) + $signed({3'b000, angle_noise_ff}));
            OP_AA_ADD:    aa_ff <= sat32(34'(aa_ff) + 34'(prod_q));
            OP_AB_BA_SUB: begin
               ab_ff <= sat32(34'(ab_ff) - 34'(r1_ff));
               ba_ff <= sat32(34'(ba_ff) - 34'(r1_ff));
            end
            OP_MUL_QB_DT: r0_ff <= prod_q;
            OP_BB_ADD:    bb_ff <= sat32(34'(bb_ff) + 34'(r0_ff));
            OP_S_FORM:    s_ff <= sat32(34'(aa_ff) + $signed({3'b000, measure_noise_ff}));
            OP_DIV_K1:    k0_ff <= div_quot;
            OP_K1_DONE:   k1_ff <= div_quot;
            OP_Y_FORM:    y_ff <= sat32(34'(meas_ff) - 34'(angle_ff));
            OP_MUL_K0_Y:  r0_ff <= prod_q;
            OP_MUL_K1_Y: begin
               angle_ff <= sat32(34'(angle_ff) + 34'(r0_ff));
               r0_ff    <= prod_q;
            end
            OP_BIAS_ADD:  bias_ff <= sat32(34'(bias_ff) + 34'(r0_ff));
            OP_MUL_K0_AA: r0_ff <= prod_q;
            OP_MUL_K0_AB: r1_ff <= prod_q;
            OP_MUL_K1_AA: r2_ff <= prod_q;
            OP_MUL_K1_AB: r3_ff <= prod_q;
            OP_COV_UPD: begin
               aa_ff <= sat32(34'(aa_ff) - 34'(r0_ff));
               ab_ff <= sat32(34'(ab_ff) - 34'(r1_ff));
               ba_ff <= sat32(34'(ba_ff) - 34'(r2_ff));
               bb_ff <= sat32(34'(bb_ff) - 34'(r3_ff));
            end
            default: ;
         endcase
      end
   end

   assign status.div_busy = div_busy;
   assign rsp_payload.filtered_angle = angle_ff;
   assign rsp_payload.bias_estimate  = bias_ff;

endmodule
`default_nettype wire

FILE: rtl/kabf_control.sv
// Sequencer of the Kalman filter unit: steps the datapath through one item.
// Uses kabf_pkg; handles req/rsp handshakes and waits on the divider.
`default_nettype none
module kabf_control
   import kabf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  wire logic      rsp_stall,
   output dp_cmd_type     cmd,
   input  wire dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_WAIT_DIV,
      ST_OUT
   } state_type;

   state_type state_ff;
   op_type    op_ff;
   logic      rsp_valid_ff;
   logic      accept;

   // new item accepted only when idle: no item in progress and no result pending
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      cmd.op = OP_NOP;
      if (accept) cmd.op = OP_LOAD;
      else if (state_ff == ST_RUN) cmd.op = op_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_NOP;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_RUN;
                  op_ff    <= OP_RATE;
               end
            end
            ST_RUN: begin
               case (op_ff)
                  OP_DIV_K0, OP_DIV_K1: state_ff <= ST_WAIT_DIV;
                  OP_COV_UPD: begin
                     state_ff     <= ST_OUT;
                     rsp_valid_ff <= 1'b1;
                  end
                  default: ;
               endcase
               op_ff <= op_type'(op_ff + 5'd1);
            end
            ST_WAIT_DIV: begin
               if (!status.div_busy) state_ff <= ST_RUN;
            end
            ST_OUT: begin
               if (!rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> state_ff == ST_OUT) else $error("rsp_valid outside output state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !accept) else $error("item accepted while busy");
   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WAIT_DIV && status.div_busy |=> state_ff == ST_WAIT_DIV)
      else $error("left divider wait early");
`endif

endmodule
`default_nettype wire

FILE: rtl/kalman_angle_bias_filter_unit.sv
// Two-state Kalman filter for angle and gyro bias, signed Q16.16 with saturation.
// Input channel req_*: valid/stall, one measured angle and gyro rate per item.
// Result channel rsp_*: valid/stall, filtered angle and bias estimate per item.
// Config channel csr_*: valid/ready write of a register index and data; always ready.
// One item is processed at a time: 24 steps on one shared 32x32 multiplier plus
// two bit-serial gain divisions, each waited on before the next step. A new item
// is accepted only after the result of the previous one has been taken.
// req_stall is high from acceptance until the result is taken; while rsp_stall
// is high the result holds on rsp_payload. Reset (synchronous, active high)
// clears the estimates and covariance and restores register defaults.
// Uses kabf_pkg, kabf_control and kabf_datapath.
`default_nettype none
module kalman_angle_bias_filter_unit
   import kabf_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_stall,
   input  wire req_payload_type req_payload,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   output rsp_payload_type      rsp_payload,
   input  wire logic            csr_valid,
   output logic                 csr_ready,
   input  wire logic [1:0]      csr_index,
   input  wire logic [31:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   kabf_control u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   kabf_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_valid),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

endmodule
`default_nettype wire
